// ===== design/tpag_pkg.sv =====
// Shared widths, reset values and register map of the tensor permute address generator.
package tpag_pkg;

    localparam int RANK_W      = 3;
    localparam int SIZE_W      = 11;
    localparam int PERM_W      = 3;
    localparam int ORDER_W     = 15;
    localparam int NUM_SIZES   = 5;
    localparam int NUM_CODES   = 1 << PERM_W;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [RANK_W-1:0]  RANK_RST  = 3'd4;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1;
    localparam logic [ORDER_W-1:0] ORDER_RST = 15'd18056;

    typedef enum logic [2:0] {
        REG_RANK    = 3'd0,
        REG_SIZE_D0 = 3'd1,
        REG_SIZE_D1 = 3'd2,
        REG_SIZE_D2 = 3'd3,
        REG_SIZE_D3 = 3'd4,
        REG_SIZE_D4 = 3'd5,
        REG_ORDER   = 3'd6
    } reg_idx_t;

endpackage

// ===== design/tensor_permute_address_generator.sv =====
// Tensor permute address generator: odometer walk of the permuted tensor with strided source index.
// Each accepted item's result is written to the output register.
// Throughput: one item per cycle; a full output register with out_stall high holds the input.
// After reset and after every configuration write the input is stalled
// while one shared multiplier builds the stride and step tables (natural strides, then deltas).
// Reset: rank 4, all sizes 1, identity order; no walk in progress, output empty.
module tensor_permute_address_generator
    import tpag_pkg::*;
#(
    parameter int MAX_RANK   = 5,
    parameter int DIM_BITS   = 10,
    parameter int INDEX_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] dst_index,
    output logic [INDEX_BITS-1:0] src_index,
    output logic                  last,
    output logic                  config_error
);

    localparam int IDXW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RUN_W = INDEX_BITS + 1;
    localparam int PW    = RUN_W + SIZE_W;
    localparam logic [PW-1:0]     IDX_LIMIT = PW'(1) << INDEX_BITS;
    localparam int unsigned       DIM_LIMIT = 32'd1 << DIM_BITS;
    localparam logic [IDXW-1:0]   IDX_TOP   = IDXW'(MAX_RANK - 1);

    // configuration registers
    logic [RANK_W-1:0]  rank_reg;
    logic [SIZE_W-1:0]  size_reg [NUM_SIZES];
    logic [ORDER_W-1:0] order_reg;

    // table builder
    logic                  busy_reg;
    logic                  phase_b_reg;
    logic [IDXW-1:0]       idx_reg;
    logic [RUN_W-1:0]      run_reg;
    logic [INDEX_BITS-1:0] acc_reg;
    logic [NUM_CODES-1:0]  seen_reg;
    logic                  err_reg;
    logic [RUN_W-1:0]      nat_reg       [MAX_RANK];
    logic [DIM_BITS-1:0]   pre_span_reg  [MAX_RANK];
    logic [INDEX_BITS-1:0] pre_delta_reg [MAX_RANK];

    // walk state
    logic                  walk_done_reg;
    logic [DIM_BITS-1:0]   coord_reg      [MAX_RANK];
    logic [DIM_BITS-1:0]   walk_span_reg  [MAX_RANK];
    logic [INDEX_BITS-1:0] walk_delta_reg [MAX_RANK];
    logic [INDEX_BITS-1:0] dst_reg;
    logic [INDEX_BITS-1:0] src_reg;

    // result register
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] dst_index_reg;
    logic [INDEX_BITS-1:0] src_index_reg;
    logic                  last_reg;
    logic                  config_error_reg;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic                  init_err;

    logic [PERM_W-1:0]     perm_sel;
    logic [PERM_W-1:0]     size_addr;
    logic [SIZE_W-1:0]     size_sel;
    logic [SIZE_W-1:0]     span_sel;
    logic [IDXW-1:0]       pidx;
    logic [RUN_W-1:0]      nat_sel;
    logic                  in_use;
    logic [SIZE_W-1:0]     mul_a;
    logic [RUN_W-1:0]      mul_b;
    logic [PW-1:0]         prod;
    logic                  step_err;

    logic                  in_acc;
    logic                  produce;
    logic                  err_case;
    logic [DIM_BITS-1:0]   cur_c     [MAX_RANK];
    logic [DIM_BITS-1:0]   cur_sp    [MAX_RANK];
    logic [INDEX_BITS-1:0] cur_d     [MAX_RANK];
    logic [DIM_BITS-1:0]   coord_next[MAX_RANK];
    logic [INDEX_BITS-1:0] cur_src;
    logic [INDEX_BITS-1:0] cur_dst;
    logic [INDEX_BITS-1:0] delta_sel;
    logic                  walk_end;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_RANK:    prdata = DATA_W'(rank_reg);
            REG_SIZE_D0: prdata = DATA_W'(size_reg[0]);
            REG_SIZE_D1: prdata = DATA_W'(size_reg[1]);
            REG_SIZE_D2: prdata = DATA_W'(size_reg[2]);
            REG_SIZE_D3: prdata = DATA_W'(size_reg[3]);
            REG_SIZE_D4: prdata = DATA_W'(size_reg[4]);
            REG_ORDER:   prdata = DATA_W'(order_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        init_err = (rank_reg == '0) || (32'(rank_reg) > 32'(MAX_RANK));
        if (cfg_wr && cfg_idx == REG_RANK)
        begin
            init_err = (pwdata[RANK_W-1:0] == '0)
                || (32'(pwdata[RANK_W-1:0]) > 32'(MAX_RANK));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg  <= RANK_RST;
            order_reg <= ORDER_RST;
            for (int j = 0; j < NUM_SIZES; j++)
            begin
                size_reg[j] <= SIZE_RST;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RANK:    rank_reg    <= pwdata[RANK_W-1:0];
                REG_SIZE_D0: size_reg[0] <= pwdata[SIZE_W-1:0];
                REG_SIZE_D1: size_reg[1] <= pwdata[SIZE_W-1:0];
                REG_SIZE_D2: size_reg[2] <= pwdata[SIZE_W-1:0];
                REG_SIZE_D3: size_reg[3] <= pwdata[SIZE_W-1:0];
                REG_SIZE_D4: size_reg[4] <= pwdata[SIZE_W-1:0];
                REG_ORDER:   order_reg   <= pwdata[ORDER_W-1:0];
                default:     ;
            endcase
        end
    end

    // table builder datapath: one multiply per step
    always_comb
    begin
        perm_sel = '0;
        for (int j = 0; j < NUM_SIZES; j++)
        begin
            if (32'(idx_reg) == j)
            begin
                perm_sel = order_reg[PERM_W*j +: PERM_W];
            end
        end
        pidx    = IDXW'(perm_sel);
        nat_sel = nat_reg[pidx];
        in_use  = 32'(idx_reg) < 32'(rank_reg);

        size_addr = phase_b_reg ? perm_sel : PERM_W'(idx_reg);
        size_sel  = SIZE_W'(1);
        for (int j = 0; j < NUM_SIZES; j++)
        begin
            if (32'(size_addr) == j)
            begin
                size_sel = size_reg[j];
            end
        end
        span_sel = size_sel - SIZE_W'(1);

        mul_a = phase_b_reg ? span_sel : size_sel;
        mul_b = phase_b_reg ? nat_sel : run_reg;
        prod  = PW'(mul_a) * PW'(mul_b);

        step_err = (32'(perm_sel) >= 32'(rank_reg)) || seen_reg[perm_sel]
            || (size_sel == '0) || (32'(size_sel) > DIM_LIMIT) || (prod > IDX_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            phase_b_reg <= 1'b0;
            idx_reg     <= IDX_TOP;
            run_reg     <= RUN_W'(1);
            acc_reg     <= '0;
            seen_reg    <= '0;
            err_reg     <= (RANK_RST == '0) || (32'(RANK_RST) > 32'(MAX_RANK));
        end
        else if (cfg_wr)
        begin
            busy_reg    <= 1'b1;
            phase_b_reg <= 1'b0;
            idx_reg     <= IDX_TOP;
            run_reg     <= RUN_W'(1);
            acc_reg     <= '0;
            seen_reg    <= '0;
            err_reg     <= init_err;
        end
        else if (busy_reg)
        begin
            if (!phase_b_reg)
            begin
                if (in_use)
                begin
                    seen_reg[perm_sel] <= 1'b1;
                    run_reg <= (prod > IDX_LIMIT) ? IDX_LIMIT[RUN_W-1:0] : prod[RUN_W-1:0];
                    if (step_err)
                    begin
                        err_reg <= 1'b1;
                    end
                end
            end
            else if (in_use)
            begin
                acc_reg <= acc_reg + prod[INDEX_BITS-1:0];
            end
            if (idx_reg == '0)
            begin
                idx_reg     <= IDX_TOP;
                phase_b_reg <= 1'b1;
                busy_reg    <= !phase_b_reg;
            end
            else
            begin
                idx_reg <= idx_reg - IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_wr)
        begin
            if (!phase_b_reg)
            begin
                nat_reg[idx_reg] <= in_use ? run_reg : RUN_W'(1);
            end
            else if (in_use)
            begin
                pre_span_reg[idx_reg]  <= DIM_BITS'(span_sel);
                pre_delta_reg[idx_reg] <= nat_sel[INDEX_BITS-1:0] - acc_reg;
            end
            else
            begin
                pre_span_reg[idx_reg]  <= '0;
                pre_delta_reg[idx_reg] <= '0;
            end
        end
    end

    // odometer step
    assign in_stall = busy_reg | (out_valid_reg & out_stall);
    assign in_acc   = in_valid & ~in_stall;
    assign produce  = in_acc & (restart | ~walk_done_reg);
    assign err_case = restart & err_reg;
    assign cur_src  = restart ? '0 : src_reg;
    assign cur_dst  = restart ? '0 : dst_reg;

    always_comb
    begin
        logic cin;
        logic maxed;
        cin       = 1'b1;
        delta_sel = '0;
        for (int i = MAX_RANK - 1; i >= 0; i--)
        begin
            cur_c[i]  = restart ? '0 : coord_reg[i];
            cur_sp[i] = restart ? pre_span_reg[i] : walk_span_reg[i];
            cur_d[i]  = restart ? pre_delta_reg[i] : walk_delta_reg[i];
            maxed     = cur_c[i] == cur_sp[i];
            coord_next[i] = cur_c[i];
            if (cin && !maxed)
            begin
                coord_next[i] = cur_c[i] + DIM_BITS'(1);
                delta_sel     = cur_d[i];
            end
            else if (cin)
            begin
                coord_next[i] = '0;
            end
            cin = cin & maxed;
        end
        walk_end = cin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_done_reg <= 1'b1;
            dst_reg       <= '0;
            src_reg       <= '0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else if (produce)
        begin
            if (err_case)
            begin
                walk_done_reg <= 1'b1;
            end
            else
            begin
                walk_done_reg <= walk_end;
                dst_reg       <= cur_dst + INDEX_BITS'(1);
                src_reg       <= cur_src + delta_sel;
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    coord_reg[i] <= coord_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce && restart && !err_reg)
        begin
            for (int i = 0; i < MAX_RANK; i++)
            begin
                walk_span_reg[i]  <= pre_span_reg[i];
                walk_delta_reg[i] <= pre_delta_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            dst_index_reg    <= err_case ? '0 : cur_dst;
            src_index_reg    <= err_case ? '0 : cur_src;
            last_reg         <= err_case | walk_end;
            config_error_reg <= err_case;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dst_index    = dst_index_reg;
    assign src_index    = src_index_reg;
    assign last         = last_reg;
    assign config_error = config_error_reg;

endmodule
